// ----- rtl/tsa_pkg.sv -----
// Shared types and constants for the Taylor-series sine block.
// No dependencies; imported by every other rtl file.
package tsa_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_W    = FRAC_BITS + 3;  // Q2.16 signed angle and result
  localparam int MAG_W      = FRAC_BITS + 2;  // |x| and every term, at most 2.0
  localparam int SQ_W       = FRAC_BITS + 3;  // x*x, at most 4.0
  localparam int P_W        = FRAC_BITS + 4;  // term*x*x, at most 8.0
  localparam int RECIP_BITS = 32;
  localparam int RECIP_W    = 30;             // 2^32/6 fits in 30 bits
  localparam int MUL_A_W    = P_W;
  localparam int MUL_B_W    = RECIP_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int IDX_W      = 5;

  // APB register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_HTI  = 1'b0;           // word index of highest_term_index
  localparam logic [IDX_W-1:0] HTI_RESET = 5'd7;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_TP,
    ST_TR,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MOP_SQ,
    MOP_TP,
    MOP_TR
  } mul_op_t;

endpackage

// ----- rtl/taylor_sine_approximator_top.sv -----
// Taylor-series sine, Q2.16 in and out, one shared multiplier.
// Sequence: one squaring pass, then two multiplier passes per term for K terms, where
// K = min(highest_term_index, MAX_TERM_INDEX), then a sign fix-up. The next request
// is taken in the out_valid cycle.
// Reset (rst_n low, synchronous): sequencer idle, no strobe, highest_term_index = 7.
// Depends on tsa_pkg, tsa_cfg, tsa_core, tsa_mul.
module taylor_sine_approximator_top #(
  parameter int MAX_TERM_INDEX = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tsa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  tsa_pkg::angle_t                   in_angle,
  output logic                              out_valid,
  output tsa_pkg::angle_t                   out_sine_value
);
  import tsa_pkg::*;

  idx_t hti;

  tsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hti     (hti)
  );

  tsa_core #(
    .MAX_TERM_INDEX (MAX_TERM_INDEX)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_angle       (in_angle),
    .hti            (hti),
    .out_valid      (out_valid),
    .out_sine_value (out_sine_value)
  );

endmodule

// ----- rtl/tsa_mul.sv -----
// Shared fixed-point multiplier: operand select, one multiply, rescaling shift.
// Depends on tsa_pkg.
module tsa_mul (
  input  tsa_pkg::mul_op_t                 op,
  input  logic [tsa_pkg::MAG_W-1:0]        term,
  input  logic [tsa_pkg::SQ_W-1:0]         sq,
  input  logic [tsa_pkg::P_W-1:0]          prod_p,
  input  logic [tsa_pkg::RECIP_W-1:0]      recip,
  output logic [tsa_pkg::P_W-1:0]          res
);
  import tsa_pkg::*;

  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    case (op)
      MOP_SQ: begin
        op_a = MUL_A_W'(term);
        op_b = MUL_B_W'(term);
      end
      MOP_TP: begin
        op_a = MUL_A_W'(term);
        op_b = MUL_B_W'(sq);
      end
      MOP_TR: begin
        op_a = prod_p;
        op_b = recip;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(op_a) * PROD_W'(op_b);

  // every rescaled product is known to fit P_W bits
  always_comb begin
    if (op == MOP_TR) begin
      res = P_W'(prod[PROD_W-1:RECIP_BITS]);
    end else begin
      res = prod[FRAC_BITS +: P_W];
    end
  end

endmodule

// ----- rtl/tsa_cfg.sv -----
// APB register file holding highest_term_index.
// Depends on tsa_pkg.
module tsa_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tsa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output tsa_pkg::idx_t                     hti
);
  import tsa_pkg::*;

  idx_t hti_r;
  idx_t hti_nxt;
  logic wr_hti;

  assign wr_hti = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_HTI);

  always_comb begin
    hti_nxt = hti_r;
    if (wr_hti) begin
      hti_nxt = pwdata[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hti_r <= HTI_RESET;
    end else begin
      hti_r <= hti_nxt;
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1] == REG_HTI) begin
      prdata = CFG_DATA_W'(hti_r);
    end else begin
      prdata = '0;
    end
  end

  assign pready = 1'b1;
  assign hti    = hti_r;

endmodule

// ----- rtl/tsa_core.sv -----
// Sequencer and datapath: square, then per term two passes through tsa_mul.
// Depends on tsa_pkg and tsa_mul.
module tsa_core #(
  parameter int MAX_TERM_INDEX = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tsa_pkg::angle_t      in_angle,
  input  tsa_pkg::idx_t        hti,
  output logic                 out_valid,
  output tsa_pkg::angle_t      out_sine_value
);
  import tsa_pkg::*;

  localparam int KW = $clog2(MAX_TERM_INDEX + 1);
  localparam int TW = (MAX_TERM_INDEX > 1) ? $clog2(MAX_TERM_INDEX) : 1;

  // reciprocal of (2k+2)(2k+3), 32 fraction bits
  logic [RECIP_W-1:0] recip_tab [MAX_TERM_INDEX];

  for (genvar g = 0; g < MAX_TERM_INDEX; g++) begin : g_recip
    localparam longint Denom = (2 * g + 2) * (2 * g + 3);
    assign recip_tab[g] = RECIP_W'((64'd1 << RECIP_BITS) / Denom);
  end

  state_t             state_r, state_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [KW-1:0]      last_r, last_nxt;
  logic               sign_r, sign_nxt;
  logic [MAG_W-1:0]   term_r, term_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [P_W-1:0]     p_r, p_nxt;
  angle_t             acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  angle_t             out_sine_value_r, out_sine_value_nxt;

  mul_op_t            mop;
  logic [P_W-1:0]     mres;
  angle_t             mag_full;
  angle_t             mag_limit;
  logic [MAG_W-1:0]   term_new;

  tsa_mul u_mul (
    .op     (mop),
    .term   (term_r),
    .sq     (sq_r),
    .prod_p (p_r),
    .recip  (recip_tab[k_r[TW-1:0]]),
    .res    (mres)
  );

  assign mag_full  = in_angle[ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;
  assign mag_limit = ANGLE_W'(2) << FRAC_BITS;
  assign term_new  = mres[MAG_W-1:0];

  always_comb begin
    state_nxt          = state_r;
    k_nxt              = k_r;
    last_nxt           = last_r;
    sign_nxt           = sign_r;
    term_nxt           = term_r;
    sq_nxt             = sq_r;
    p_nxt              = p_r;
    acc_nxt            = acc_r;
    out_valid_nxt      = 1'b0;
    out_sine_value_nxt = out_sine_value_r;
    mop                = MOP_SQ;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sign_nxt = in_angle[ANGLE_W-1];
          if (mag_full > mag_limit) begin
            term_nxt = MAG_W'(mag_limit);
          end else begin
            term_nxt = MAG_W'(mag_full);
          end
          acc_nxt = ANGLE_W'(term_nxt);
          k_nxt   = '0;
          if (32'(hti) > MAX_TERM_INDEX) begin
            last_nxt = KW'(MAX_TERM_INDEX);
          end else begin
            last_nxt = KW'(hti);
          end
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mop    = MOP_SQ;
        sq_nxt = mres[SQ_W-1:0];
        state_nxt = (last_r == '0) ? ST_FIN : ST_TP;
      end
      ST_TP: begin
        mop       = MOP_TP;
        p_nxt     = mres;
        state_nxt = ST_TR;
      end
      ST_TR: begin
        mop      = MOP_TR;
        term_nxt = term_new;
        // term k+1 is subtracted when k is even
        if (k_r[0]) begin
          acc_nxt = acc_r + ANGLE_W'(term_new);
        end else begin
          acc_nxt = acc_r - ANGLE_W'(term_new);
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_nxt == last_r) ? ST_FIN : ST_TP;
      end
      ST_FIN: begin
        out_valid_nxt      = 1'b1;
        out_sine_value_nxt = sign_r ? (~acc_r + 1'b1) : acc_r;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r              <= k_nxt;
    last_r           <= last_nxt;
    sign_r           <= sign_nxt;
    term_r           <= term_nxt;
    sq_r             <= sq_nxt;
    p_r              <= p_nxt;
    acc_r            <= acc_nxt;
    out_sine_value_r <= out_sine_value_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_value_r;

endmodule
